[src/dfl_pkg.sv]
// Shared types, codes and reset constants for the DNS feature level tracker.
// No dependencies; imported by dfl_update and dns_feature_level_tracker.
package dfl_pkg;

  // Feature levels
  localparam logic [2:0] LVL_TCP   = 3'd0;
  localparam logic [2:0] LVL_UDP   = 3'd1;
  localparam logic [2:0] LVL_EDNS0 = 3'd2;
  localparam logic [2:0] LVL_DO    = 3'd3;
  localparam logic [2:0] LVL_LARGE = 3'd4;

  // Event codes; 6 and 7 are no-ops
  localparam logic [2:0] OP_RECEIVED  = 3'd0;
  localparam logic [2:0] OP_LOST      = 3'd1;
  localparam logic [2:0] OP_FAILED    = 3'd2;
  localparam logic [2:0] OP_TRUNCATED = 3'd3;
  localparam logic [2:0] OP_RRSIG     = 3'd4;
  localparam logic [2:0] OP_QUERY     = 3'd5;

  // Transport codes; 2 and 3 are other protocols
  localparam logic [1:0] TR_UDP = 2'd0;
  localparam logic [1:0] TR_TCP = 2'd1;

  // Register reset values
  localparam logic [7:0]  RST_RETRY_LIMIT = 8'd3;
  localparam logic [22:0] RST_TIMEOUT_MIN = 23'd500000;
  localparam logic [22:0] RST_TIMEOUT_MAX = 23'd5000000;
  localparam logic [34:0] RST_GRACE_MIN   = 35'd300000000;
  localparam logic [34:0] RST_GRACE_MAX   = 35'd21600000000;
  localparam logic [15:0] RST_INIT_UDP    = 16'd512;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [22:0] timeout_min_us;
    logic [22:0] timeout_max_us;
    logic [34:0] grace_min_us;
    logic [34:0] grace_max_us;
    logic [15:0] initial_udp_size;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  transport;
    logic [2:0]  used_level;
    logic [31:0] round_trip_us;
    logic [15:0] reply_size;
    logic [31:0] waited_us;
    logic [47:0] now_us;
  } item_t;

  typedef struct packed {
    logic [2:0]  possible_level;
    logic        verified_valid;
    logic [2:0]  verified_level;
    logic [47:0] verified_time;
    logic [34:0] grace_period;
    logic [7:0]  udp_failures;
    logic [7:0]  tcp_failures;
    logic        failed_flag;
    logic        truncated_flag;
    logic        rrsig_miss_flag;
    logic [15:0] largest_udp;
    logic [31:0] largest_rtt;
    logic [22:0] retx_timeout;
  } state_t;

  typedef struct packed {
    logic [2:0]  level;
    logic        level_changed;
    logic        dnssec_ok;
    logic [22:0] resend_timeout_us;
    logic [15:0] udp_size_max;
  } result_t;

  localparam state_t STATE_RESET = '{
    possible_level:  LVL_LARGE,
    verified_valid:  1'b0,
    verified_level:  LVL_TCP,
    verified_time:   48'd0,
    grace_period:    RST_GRACE_MIN,
    udp_failures:    8'd0,
    tcp_failures:    8'd0,
    failed_flag:     1'b0,
    truncated_flag:  1'b0,
    rrsig_miss_flag: 1'b0,
    largest_udp:     RST_INIT_UDP,
    largest_rtt:     32'd0,
    retx_timeout:    RST_TIMEOUT_MIN
  };

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 8'd1;
  endfunction

endpackage

[src/dns_feature_level_tracker.sv]
// Top level of the DNS server feature level tracker: channels, registers, state.
// Depends on dfl_pkg and dfl_update.
//
// Usage:
//   Input channel in_*: one event transaction (op, transport, used_level, round_trip_us,
//   reply_size, waited_us, now_us) moves when in_valid is high and in_stall is low.
//   Output channel out_*: one result transaction per event (level, level_changed,
//   dnssec_ok, resend_timeout_us, udp_size_max) moves when out_valid is high and
//   out_stall is low.
//   An accepted event is held in the input register, evaluated by the update logic, and
//   its result captured in the result register. Throughput: one event per cycle while
//   out_stall is low, set by the single input register and result register around the
//   update logic; state is written back in the same cycle the event is evaluated.
//   Stall: while the result register is full and stalled, the input register holds one
//   more event and in_stall rises once it is occupied.
//   Reset (rst_n low, synchronous): configuration registers return to their defaults,
//   tracker state returns to level LARGE with nothing verified, both registers empty.
//   Configuration: APB port, 64-bit data, register i at byte address 8*i; write only
//   while no transaction is in flight.
module dns_feature_level_tracker
  import dfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Event input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [1:0]  in_transport,
  input  logic [2:0]  in_used_level,
  input  logic [31:0] in_round_trip_us,
  input  logic [15:0] in_reply_size,
  input  logic [31:0] in_waited_us,
  input  logic [47:0] in_now_us,
  // Result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_level,
  output logic        out_level_changed,
  output logic        out_dnssec_ok,
  output logic [22:0] out_resend_timeout_us,
  output logic [15:0] out_udp_size_max
);

  localparam logic [2:0] REG_RETRY_LIMIT = 3'd0;
  localparam logic [2:0] REG_TIMEOUT_MIN = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_MAX = 3'd2;
  localparam logic [2:0] REG_GRACE_MIN   = 3'd3;
  localparam logic [2:0] REG_GRACE_MAX   = 3'd4;
  localparam logic [2:0] REG_INIT_UDP    = 3'd5;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  item_t   item_r;
  logic    in_valid_r;
  logic    out_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    cfg_wr;
  logic    in_take;
  logic    proc;

  // Configuration writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit      <= RST_RETRY_LIMIT;
      cfg_r.timeout_min_us   <= RST_TIMEOUT_MIN;
      cfg_r.timeout_max_us   <= RST_TIMEOUT_MAX;
      cfg_r.grace_min_us     <= RST_GRACE_MIN;
      cfg_r.grace_max_us     <= RST_GRACE_MAX;
      cfg_r.initial_udp_size <= RST_INIT_UDP;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_RETRY_LIMIT: cfg_r.retry_limit      <= pwdata[7:0];
        REG_TIMEOUT_MIN: cfg_r.timeout_min_us   <= pwdata[22:0];
        REG_TIMEOUT_MAX: cfg_r.timeout_max_us   <= pwdata[22:0];
        REG_GRACE_MIN:   cfg_r.grace_min_us     <= pwdata[34:0];
        REG_GRACE_MAX:   cfg_r.grace_max_us     <= pwdata[34:0];
        REG_INIT_UDP:    cfg_r.initial_udp_size <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[5:3])
      REG_RETRY_LIMIT: prdata = {56'd0, cfg_r.retry_limit};
      REG_TIMEOUT_MIN: prdata = {41'd0, cfg_r.timeout_min_us};
      REG_TIMEOUT_MAX: prdata = {41'd0, cfg_r.timeout_max_us};
      REG_GRACE_MIN:   prdata = {29'd0, cfg_r.grace_min_us};
      REG_GRACE_MAX:   prdata = {29'd0, cfg_r.grace_max_us};
      REG_INIT_UDP:    prdata = {48'd0, cfg_r.initial_udp_size};
      default:         prdata = 64'd0;
    endcase
  end

  // Handshake: evaluate when an event is held and the result slot is free
  assign proc     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op            <= in_op;
      item_r.transport     <= in_transport;
      item_r.used_level    <= in_used_level;
      item_r.round_trip_us <= in_round_trip_us;
      item_r.reply_size    <= in_reply_size;
      item_r.waited_us     <= in_waited_us;
      item_r.now_us        <= in_now_us;
    end
  end

  dfl_update u_update (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Advance tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_level             = res_r.level;
  assign out_level_changed     = res_r.level_changed;
  assign out_dnssec_ok         = res_r.dnssec_ok;
  assign out_resend_timeout_us = res_r.resend_timeout_us;
  assign out_udp_size_max      = res_r.udp_size_max;

endmodule

[src/dfl_update.sv]
// Next-state and result logic for one event of the feature level tracker.
// Purely combinational; uses types and codes from dfl_pkg.
module dfl_update
  import dfl_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  cur,
  input  item_t   item,
  output state_t  nxt,
  output result_t res
);

  logic [2:0]  lvl;
  logic [2:0]  ver_lvl;
  logic        ver_take;
  logic [32:0] rtt_dbl;
  logic [23:0] rto_dbl;
  logic [48:0] grace_end;
  logic [35:0] grace_dbl;
  logic        grace_over;
  logic        tcp_bad;
  logic        step_down;

  always_comb begin
    // Clamp levels above LARGE
    lvl = (item.used_level > LVL_LARGE) ? LVL_LARGE : item.used_level;

    // Verification level for a received reply
    if (item.transport == TR_UDP) begin
      ver_lvl = (lvl == LVL_LARGE) ? LVL_DO : lvl;
    end else begin
      ver_lvl = LVL_TCP;
    end
    ver_take = !(cur.verified_valid && (cur.verified_level > ver_lvl));

    rtt_dbl   = {item.round_trip_us, 1'b0};
    rto_dbl   = {cur.retx_timeout, 1'b0};
    grace_end = {1'b0, cur.verified_time} + {14'd0, cur.grace_period};
    grace_dbl = {cur.grace_period, 1'b0};
    grace_over = (cur.possible_level != LVL_LARGE) && (cur.verified_time != 48'd0) &&
                 (grace_end <= {1'b0, item.now_us});
    tcp_bad   = cur.tcp_failures >= cfg.retry_limit;
    step_down = ((cur.udp_failures >= cfg.retry_limit) && (cur.possible_level >= LVL_UDP)) ||
                (cur.failed_flag && (cur.possible_level > LVL_UDP)) ||
                (tcp_bad && cur.truncated_flag && (cur.possible_level > LVL_UDP));

    nxt = cur;
    case (item.op)
      OP_RECEIVED: begin
        if (item.transport == TR_UDP || item.transport == TR_TCP) begin
          if (cur.possible_level == lvl) begin
            if (item.transport == TR_UDP) begin
              nxt.udp_failures = 8'd0;
            end else begin
              nxt.tcp_failures = 8'd0;
            end
          end
          if (ver_take) begin
            nxt.verified_valid = 1'b1;
            nxt.verified_level = ver_lvl;
            nxt.verified_time  = item.now_us;
          end
          if (item.transport == TR_UDP && cur.largest_udp < item.reply_size) begin
            nxt.largest_udp = item.reply_size;
          end
        end
        // Track the worst RTT and derive the timeout from it
        if (cur.largest_rtt < item.round_trip_us) begin
          nxt.largest_rtt = item.round_trip_us;
          if (rtt_dbl > {10'd0, cfg.timeout_max_us}) begin
            nxt.retx_timeout = cfg.timeout_max_us;
          end else if (rtt_dbl < {10'd0, cfg.timeout_min_us}) begin
            nxt.retx_timeout = cfg.timeout_min_us;
          end else begin
            nxt.retx_timeout = rtt_dbl[22:0];
          end
        end
      end
      OP_LOST: begin
        if (cur.possible_level == lvl) begin
          if (item.transport == TR_UDP) begin
            nxt.udp_failures = sat_inc(cur.udp_failures);
          end else if (item.transport == TR_TCP) begin
            nxt.tcp_failures = sat_inc(cur.tcp_failures);
          end
        end
        // Back off the timeout when it expired
        if ({9'd0, cur.retx_timeout} <= item.waited_us) begin
          nxt.retx_timeout = (rto_dbl < {1'b0, cfg.timeout_max_us}) ?
                             rto_dbl[22:0] : cfg.timeout_max_us;
        end
      end
      OP_FAILED: begin
        if (cur.possible_level == lvl) begin
          nxt.failed_flag = 1'b1;
        end
      end
      OP_TRUNCATED: begin
        if (cur.possible_level == lvl) begin
          nxt.truncated_flag = 1'b1;
        end
      end
      OP_RRSIG: begin
        nxt.rrsig_miss_flag = 1'b1;
      end
      OP_QUERY: begin
        if (grace_over) begin
          // Retry the best level and double the grace period
          nxt.grace_period = (grace_dbl < {1'b0, cfg.grace_max_us}) ?
                             grace_dbl[34:0] : cfg.grace_max_us;
          nxt.possible_level  = LVL_LARGE;
          nxt.rrsig_miss_flag = 1'b0;
          nxt.udp_failures    = 8'd0;
          nxt.tcp_failures    = 8'd0;
          nxt.failed_flag     = 1'b0;
          nxt.truncated_flag  = 1'b0;
          nxt.verified_time   = 48'd0;
        end else if (cur.verified_valid && (cur.possible_level <= cur.verified_level)) begin
          nxt.possible_level = cur.verified_level;
        end else begin
          if (tcp_bad && (cur.possible_level == LVL_TCP)) begin
            nxt.possible_level = LVL_UDP;
          end else if (step_down) begin
            nxt.possible_level = cur.possible_level - 3'd1;
          end
          if (nxt.possible_level != cur.possible_level) begin
            nxt.udp_failures   = 8'd0;
            nxt.tcp_failures   = 8'd0;
            nxt.failed_flag    = 1'b0;
            nxt.truncated_flag = 1'b0;
            nxt.verified_time  = 48'd0;
          end
        end
      end
      default: begin
      end
    endcase

    // Result from the updated state
    res.level             = nxt.possible_level;
    res.level_changed     = (item.op == OP_QUERY) && (nxt.possible_level != cur.possible_level);
    res.dnssec_ok         = (nxt.possible_level >= LVL_DO) && !nxt.rrsig_miss_flag &&
                            (nxt.tcp_failures < cfg.retry_limit);
    res.resend_timeout_us = nxt.retx_timeout;
    res.udp_size_max      = nxt.largest_udp;
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench for dns_feature_level_tracker: a directed script, then random events.
// Uses dfl_pkg for codes and payload types; drives the APB register port and both channels.
`timescale 1ns / 1ps

module testbench;
  import dfl_pkg::*;

  // Codes that the package leaves unnamed
  localparam logic [1:0] TR_OTHER    = 2'd2;
  localparam logic [1:0] TR_OTHER_HI = 2'd3;
  localparam logic [2:0] OP_NOP_LO   = 3'd6;
  localparam logic [2:0] OP_NOP_HI   = 3'd7;

  // Register indexes, 8 bytes apart on the APB port
  localparam logic [2:0] REG_RETRY     = 3'd0;
  localparam logic [2:0] REG_TMO_MIN   = 3'd1;
  localparam logic [2:0] REG_TMO_MAX   = 3'd2;
  localparam logic [2:0] REG_GRACE_MIN = 3'd3;
  localparam logic [2:0] REG_GRACE_MAX = 3'd4;
  localparam logic [2:0] REG_UDP_INIT  = 3'd5;

  localparam int PHASES = 8;
  localparam int PHASE_EVENTS = 237;

  typedef struct packed {
    item_t   ev;
    logic    typed;
    result_t want;
  } script_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  wire  [63:0] prdata;
  wire         pready;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic [2:0]  in_op = '0;
  logic [1:0]  in_transport = '0;
  logic [2:0]  in_used_level = '0;
  logic [31:0] in_round_trip_us = '0;
  logic [15:0] in_reply_size = '0;
  logic [31:0] in_waited_us = '0;
  logic [47:0] in_now_us = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [2:0]  out_level;
  wire         out_level_changed;
  wire         out_dnssec_ok;
  wire  [22:0] out_resend_timeout_us;
  wire  [15:0] out_udp_size_max;

  dns_feature_level_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_transport(in_transport), .in_used_level(in_used_level),
    .in_round_trip_us(in_round_trip_us), .in_reply_size(in_reply_size),
    .in_waited_us(in_waited_us), .in_now_us(in_now_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_level(out_level),
    .out_level_changed(out_level_changed), .out_dnssec_ok(out_dnssec_ok),
    .out_resend_timeout_us(out_resend_timeout_us), .out_udp_size_max(out_udp_size_max)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up well past the slowest legal run
  initial begin
    #2_000_000;
    $display("dns_feature_level_tracker: mismatch");
    $finish;
  end

  // Shadow registers and tracker state
  cfg_t        regs;
  logic [2:0]  lvl_now;
  logic        ver_ok;
  logic [2:0]  ver_lvl;
  logic [47:0] ver_stamp;
  logic [34:0] grace;
  logic [7:0]  udp_fails;
  logic [7:0]  tcp_fails;
  logic        saw_fail;
  logic        saw_trunc;
  logic        saw_rrsig_miss;
  logic [15:0] max_udp;
  logic [31:0] max_rtt;
  logic [22:0] resend;

  result_t     expected_results [$];
  script_row_t script [$];
  logic [47:0] clock_us = '0;
  bit          steady = 1'b0;
  int          mismatches = 0;
  int          events_sent = 0;
  int          results_checked = 0;

  // Raise the verified level, never lower it
  task automatic note_verified(input logic [2:0] lv, input logic [47:0] t);
    if (!(ver_ok && ver_lvl > lv)) begin
      ver_ok = 1'b1;
      ver_lvl = lv;
      ver_stamp = t;
    end
  endtask

  task automatic drop_evidence();
    udp_fails = '0;
    tcp_fails = '0;
    saw_fail = 1'b0;
    saw_trunc = 1'b0;
    ver_stamp = '0;
  endtask

  // Query: back to LARGE after the grace period, snap up to verified, or step down
  task automatic apply_query(input logic [47:0] t);
    logic [2:0]  prior;
    logic [35:0] doubled;
    logic        expired;
    logic        tcp_bad;
    prior = lvl_now;
    expired = 1'b0;
    if (lvl_now != LVL_LARGE && ver_stamp != '0 &&
        64'(ver_stamp) + 64'(grace) <= 64'(t)) begin
      expired = 1'b1;
      doubled = {grace, 1'b0};
      grace = (doubled < {1'b0, regs.grace_max_us}) ? doubled[34:0] : regs.grace_max_us;
    end
    if (expired) begin
      lvl_now = LVL_LARGE;
      saw_rrsig_miss = 1'b0;
      drop_evidence();
    end else if (ver_ok && lvl_now <= ver_lvl) begin
      lvl_now = ver_lvl;
    end else begin
      tcp_bad = tcp_fails >= regs.retry_limit;
      if (tcp_bad && lvl_now == LVL_TCP)
        lvl_now = LVL_UDP;
      else if ((udp_fails >= regs.retry_limit && lvl_now >= LVL_UDP) ||
               (saw_fail && lvl_now > LVL_UDP) ||
               (tcp_bad && saw_trunc && lvl_now > LVL_UDP))
        lvl_now = lvl_now - 3'd1;
      if (lvl_now != prior) drop_evidence();
    end
  endtask

  // Advance the shadow tracker by one event and form its result
  task automatic track_event(input item_t ev, output result_t res);
    logic [2:0]  lv;
    logic [2:0]  prior;
    logic [32:0] twice_rtt;
    logic [23:0] twice_tmo;
    prior = lvl_now;
    lv = (ev.used_level > LVL_LARGE) ? LVL_LARGE : ev.used_level;
    case (ev.op)
      OP_RECEIVED: begin
        if (ev.transport == TR_UDP) begin
          if (lvl_now == lv) udp_fails = '0;
          note_verified((lv == LVL_LARGE) ? LVL_DO : lv, ev.now_us);
          if (max_udp < ev.reply_size) max_udp = ev.reply_size;
        end else if (ev.transport == TR_TCP) begin
          if (lvl_now == lv) tcp_fails = '0;
          note_verified(LVL_TCP, ev.now_us);
        end
        if (max_rtt < ev.round_trip_us) begin
          twice_rtt = {ev.round_trip_us, 1'b0};
          max_rtt = ev.round_trip_us;
          if (twice_rtt > regs.timeout_max_us) resend = regs.timeout_max_us;
          else if (twice_rtt < regs.timeout_min_us) resend = regs.timeout_min_us;
          else resend = twice_rtt[22:0];
        end
      end
      OP_LOST: begin
        if (lvl_now == lv) begin
          if (ev.transport == TR_UDP && udp_fails != 8'hFF) udp_fails = udp_fails + 8'd1;
          if (ev.transport == TR_TCP && tcp_fails != 8'hFF) tcp_fails = tcp_fails + 8'd1;
        end
        if (resend <= ev.waited_us) begin
          twice_tmo = {resend, 1'b0};
          resend = (twice_tmo < regs.timeout_max_us) ? twice_tmo[22:0] : regs.timeout_max_us;
        end
      end
      OP_FAILED:    if (lvl_now == lv) saw_fail = 1'b1;
      OP_TRUNCATED: if (lvl_now == lv) saw_trunc = 1'b1;
      OP_RRSIG:     saw_rrsig_miss = 1'b1;
      OP_QUERY:     apply_query(ev.now_us);
      default: ;
    endcase
    res.level = lvl_now;
    res.level_changed = (ev.op == OP_QUERY) && (lvl_now != prior);
    res.dnssec_ok = (lvl_now >= LVL_DO) && !saw_rrsig_miss && (tcp_fails < regs.retry_limit);
    res.resend_timeout_us = resend;
    res.udp_size_max = max_udp;
  endtask

  function automatic item_t stim(input logic [2:0] op, input logic [1:0] tr,
                                 input logic [2:0] lv, input logic [31:0] rtt,
                                 input logic [15:0] size, input logic [31:0] waited,
                                 input logic [47:0] t);
    item_t ev;
    ev.op = op;
    ev.transport = tr;
    ev.used_level = lv;
    ev.round_trip_us = rtt;
    ev.reply_size = size;
    ev.waited_us = waited;
    ev.now_us = t;
    return ev;
  endfunction

  function automatic result_t outcome(input logic [2:0] lv, input logic chg, input logic ok,
                                      input logic [22:0] tmo, input logic [15:0] udp);
    result_t res;
    res.level = lv;
    res.level_changed = chg;
    res.dnssec_ok = ok;
    res.resend_timeout_us = tmo;
    res.udp_size_max = udp;
    return res;
  endfunction

  task automatic add_row(input item_t ev, input logic typed, input result_t want);
    script_row_t r;
    r.ev = ev;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endtask

  // Random event; the used level mostly follows the current level so failures count
  task automatic make_event(input bit wide, output item_t ev);
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    ev.op = (pick < 22) ? OP_RECEIVED : (pick < 42) ? OP_LOST : (pick < 50) ? OP_FAILED :
            (pick < 57) ? OP_TRUNCATED : (pick < 59) ? OP_RRSIG : (pick < 97) ? OP_QUERY :
            ($urandom_range(0, 1) != 0) ? OP_NOP_HI : OP_NOP_LO;
    pick = $urandom_range(0, 99);
    ev.transport = (pick < 55) ? TR_UDP : (pick < 90) ? TR_TCP :
                   (pick < 97) ? TR_OTHER : TR_OTHER_HI;
    ev.used_level = ($urandom_range(0, 3) != 0) ? lvl_now : 3'($urandom_range(0, 7));
    ev.round_trip_us = wide ? $urandom : $urandom_range(max_rtt >> 1, max_rtt + 200000);
    span = int'(max_udp) + 200;
    if (span > 65535) span = 65535;
    ev.reply_size = wide ? 16'($urandom) : 16'($urandom_range(0, span));
    ev.waited_us = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 2 * resend) : $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60) clock_us = clock_us + 48'($urandom_range(0, 5000));
    else if (pick < 85) clock_us = clock_us + 48'($urandom_range(0, 1 << 22));
    else if (pick < 97) clock_us = clock_us + (48'($urandom) << 3);
    else clock_us = {16'($urandom), 32'($urandom)};
    ev.now_us = clock_us;
  endtask

  // Present one transaction, hold it through stalls, predict once it is taken
  task automatic send_event(input item_t ev, input logic typed, input result_t want);
    result_t pred;
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_op <= ev.op;
    in_transport <= ev.transport;
    in_used_level <= ev.used_level;
    in_round_trip_us <= ev.round_trip_us;
    in_reply_size <= ev.reply_size;
    in_waited_us <= ev.waited_us;
    in_now_us <= ev.now_us;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_event(ev, pred);
    expected_results.push_back(typed ? want : pred);
    events_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  // APB write, then read the register back
  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      if (mismatches < 10)
        $display("%0t: register %0d reads %0h, wrote %0h", $realtime, idx, prdata, value);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_RETRY:     regs.retry_limit = value[7:0];
      REG_TMO_MIN:   regs.timeout_min_us = value[22:0];
      REG_TMO_MAX:   regs.timeout_max_us = value[22:0];
      REG_GRACE_MIN: regs.grace_min_us = value[34:0];
      REG_GRACE_MAX: regs.grace_max_us = value[34:0];
      REG_UDP_INIT:  regs.initial_udp_size = value[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t s);
    write_register(REG_RETRY, 64'(s.retry_limit));
    write_register(REG_TMO_MIN, 64'(s.timeout_min_us));
    write_register(REG_TMO_MAX, 64'(s.timeout_max_us));
    write_register(REG_GRACE_MIN, 64'(s.grace_min_us));
    write_register(REG_GRACE_MAX, 64'(s.grace_max_us));
    write_register(REG_UDP_INIT, 64'(s.initial_udp_size));
  endtask

  // Random backpressure on the result side
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 17);
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = outcome(out_level, out_level_changed, out_dnssec_ok,
                    out_resend_timeout_us, out_udp_size_max);
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing pending: level %0d changed %0b dnssec %0b tmo %0d udp %0d",
                   $realtime, got.level, got.level_changed, got.dnssec_ok,
                   got.resend_timeout_us, got.udp_size_max);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.level !== want.level || got.level_changed !== want.level_changed ||
            got.dnssec_ok !== want.dnssec_ok ||
            got.resend_timeout_us !== want.resend_timeout_us ||
            got.udp_size_max !== want.udp_size_max) begin
          if (mismatches < 10)
            $display("%0t: result %0d exp/got: level %0d/%0d changed %0b/%0b dnssec %0b/%0b tmo %0d/%0d udp %0d/%0d",
                     $realtime, results_checked, want.level, got.level,
                     want.level_changed, got.level_changed, want.dnssec_ok, got.dnssec_ok,
                     want.resend_timeout_us, got.resend_timeout_us,
                     want.udp_size_max, got.udp_size_max);
          mismatches++;
        end
      end
    end
  end

  initial begin : run
    item_t       ev;
    cfg_t        plan [PHASES];
    int unsigned phase;
    int unsigned k;

    // Reset values of registers and tracker
    regs = '{8'd3, 23'd500000, 23'd5000000, 35'd300000000, 35'd21600000000, 16'd512};
    lvl_now = LVL_LARGE;
    ver_ok = 1'b0;
    ver_lvl = LVL_TCP;
    ver_stamp = '0;
    grace = regs.grace_min_us;
    udp_fails = '0;
    tcp_fails = '0;
    saw_fail = 1'b0;
    saw_trunc = 1'b0;
    saw_rrsig_miss = 1'b0;
    max_udp = regs.initial_udp_size;
    max_rtt = '0;
    resend = regs.timeout_min_us;

    // Directed script: reset outputs, ignored ops, each downgrade path,
    // verification at time zero, snap-up and the grace-period return
    add_row(stim(OP_QUERY, TR_UDP, LVL_LARGE, 0, 0, 0, 0), 1'b1,
            outcome(LVL_LARGE, 1'b0, 1'b1, 23'd500000, 16'd512));
    add_row(stim(OP_NOP_LO, TR_OTHER_HI, 3'd7, 32'hFFFF_FFFF, 0, 0, 0), 1'b1,
            outcome(LVL_LARGE, 1'b0, 1'b1, 23'd500000, 16'd512));
    add_row(stim(OP_NOP_HI, TR_UDP, LVL_TCP, 0, 0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF), 1'b1,
            outcome(LVL_LARGE, 1'b0, 1'b1, 23'd500000, 16'd512));
    add_row(stim(OP_LOST, TR_UDP, LVL_LARGE, 0, 0, 0, 100), 1'b1,
            outcome(LVL_LARGE, 1'b0, 1'b1, 23'd500000, 16'd512));
    add_row(stim(OP_LOST, TR_UDP, 3'd7, 0, 0, 32'hFFFF_FFFF, 200), 1'b1,
            outcome(LVL_LARGE, 1'b0, 1'b1, 23'd1000000, 16'd512));
    add_row(stim(OP_LOST, TR_UDP, LVL_LARGE, 0, 0, 1000000, 300), 1'b1,
            outcome(LVL_LARGE, 1'b0, 1'b1, 23'd2000000, 16'd512));
    add_row(stim(OP_QUERY, TR_UDP, LVL_LARGE, 0, 0, 0, 1000), 1'b1,
            outcome(LVL_DO, 1'b1, 1'b1, 23'd2000000, 16'd512));
    add_row(stim(OP_FAILED, TR_UDP, LVL_DO, 0, 0, 0, 1100), 1'b1,
            outcome(LVL_DO, 1'b0, 1'b1, 23'd2000000, 16'd512));
    add_row(stim(OP_QUERY, TR_UDP, LVL_DO, 0, 0, 0, 2000), 1'b1,
            outcome(LVL_EDNS0, 1'b1, 1'b0, 23'd2000000, 16'd512));
    add_row(stim(OP_TRUNCATED, TR_UDP, LVL_EDNS0, 0, 0, 0, 2100), 1'b0, '0);
    repeat (3) add_row(stim(OP_LOST, TR_TCP, LVL_EDNS0, 0, 0, 0, 2200), 1'b0, '0);
    add_row(stim(OP_QUERY, TR_UDP, LVL_EDNS0, 0, 0, 0, 3000), 1'b0, '0);
    add_row(stim(OP_RECEIVED, TR_UDP, LVL_DO, 0, 0, 0, 0), 1'b0, '0);
    add_row(stim(OP_QUERY, TR_UDP, LVL_UDP, 0, 0, 0, 48'h0100_0000_0000), 1'b0, '0);
    add_row(stim(OP_RECEIVED, TR_UDP, LVL_LARGE, 100000, 1400, 0, 7000), 1'b0, '0);
    add_row(stim(OP_RECEIVED, TR_TCP, LVL_DO, 3000000, 16'hFFFF, 0, 8000), 1'b0, '0);
    add_row(stim(OP_RRSIG, TR_UDP, LVL_DO, 0, 0, 0, 9000), 1'b0, '0);
    add_row(stim(OP_QUERY, TR_UDP, LVL_DO, 0, 0, 0, 300007000), 1'b0, '0);
    add_row(stim(OP_RECEIVED, TR_OTHER, LVL_TCP, 4000000, 0, 0, 300008000), 1'b0, '0);
    add_row(stim(OP_LOST, TR_OTHER, LVL_LARGE, 0, 0, 32'hFFFF_FFFF, 300009000), 1'b0, '0);
    add_row(stim(OP_QUERY, TR_UDP, LVL_LARGE, 0, 0, 0, 48'hFFFF_FFFF_FFFF), 1'b0, '0);

    // Register settings per phase; zero clamps come late since a zero grace stays zero
    plan[0] = regs;
    plan[1] = '{8'd1, 23'd1, 23'h7FFFFF, 35'd1, 35'd1000, 16'd0};
    plan[2] = '{8'hFF, 23'h7FFFFF, 23'd1, 35'h7_FFFF_FFFF, 35'h7_FFFF_FFFF, 16'hFFFF};
    plan[3] = '{8'd2, 23'd200000, 23'd3000000, 35'd5000, 35'd80000, 16'd1232};
    plan[4] = '{8'($urandom_range(0, 6)), 23'($urandom), 23'($urandom),
                35'($urandom_range(0, 1 << 24)), {3'($urandom), 32'($urandom)}, 16'($urandom)};
    plan[5] = '{8'($urandom_range(0, 6)), 23'($urandom), 23'($urandom),
                35'($urandom_range(0, 1 << 24)), {3'($urandom), 32'($urandom)}, 16'($urandom)};
    plan[6] = '{8'd0, 23'd0, 23'd0, 35'd0, 35'd0, 16'd0};
    plan[7] = regs;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);

    // Random phases; the first runs with no idling on either side
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        settle();
        repeat (4) @(negedge clk);
        load_settings(plan[phase]);
      end
      steady = (phase == 0);
      clock_us = clock_us + 48'($urandom_range(0, 1000));
      for (k = 0; k < PHASE_EVENTS; k++) begin
        if (phase == 2 && k == 100) settle();
        make_event(phase == PHASES - 1, ev);
        send_event(ev, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d events (directed script, then %0d register settings incl. extremes)",
             events_sent, PHASES);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("dns_feature_level_tracker: match");
    else
      $display("dns_feature_level_tracker: mismatch");
    $finish;
  end

endmodule
